// ===== rtl/pse_pkg.sv =====
package pse_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int SLOT_W = 5;
	localparam int CNT_OUT_W = 5;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// common width for position/fill compares
	localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	typedef enum logic [2:0] {
		FN_PUSH   = 3'd0,
		FN_POP    = 3'd1,
		FN_INSERT = 3'd2,
		FN_REMOVE = 3'd3,
		FN_READ   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		SH_HOLD   = 2'd0,
		SH_INSERT = 2'd1,
		SH_REMOVE = 2'd2
	} shift_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		shift_t                    shift;
		logic [CMP_W-1:0]          pos;
		logic signed [DATA_W-1:0]  wdata;
	} cell_ctl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  data;
		logic [CNT_OUT_W-1:0]      count;
		stat_t                     status;
	} result_t;

endpackage

// ===== rtl/pse_cell.sv =====
module pse_cell (
	input  logic                                 clk,
	input  logic [pse_pkg::IDX_W-1:0]            idx,
	input  pse_pkg::cell_ctl_t                   ctl,
	input  logic signed [pse_pkg::DATA_W-1:0]    up_word,
	input  logic signed [pse_pkg::DATA_W-1:0]    dn_word,
	output logic signed [pse_pkg::DATA_W-1:0]    word,
	output logic signed [pse_pkg::DATA_W-1:0]    rd_word
);

	logic signed [pse_pkg::DATA_W-1:0] word_q;
	logic [pse_pkg::CMP_W-1:0]         idx_x;

	assign idx_x = pse_pkg::CMP_W'(idx);

	// entry storage has no reset, only written slots are ever read
	always_ff @(posedge clk) begin
		unique case (ctl.shift)
			pse_pkg::SH_INSERT: begin
				if (idx_x == ctl.pos) begin
					word_q <= ctl.wdata;
				end else if (idx_x > ctl.pos) begin
					word_q <= up_word;
				end
			end
			pse_pkg::SH_REMOVE: begin
				if (idx_x >= ctl.pos) begin
					word_q <= dn_word;
				end
			end
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	assign word    = word_q;
	assign rd_word = (idx_x == ctl.pos) ? word_q : '0;

endmodule

// ===== rtl/pse_outq.sv =====
module pse_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pse_pkg::result_t   res,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output pse_pkg::result_t   out_res
);

	logic              out_v_q;
	logic              skid_v_q;
	pse_pkg::result_t  out_q;
	pse_pkg::result_t  skid_q;
	logic              take;
	logic              load_out_res;
	logic              load_out_skid;
	logic              load_skid;

	assign take          = out_v_q & ~out_stall;
	assign load_out_skid = skid_v_q & take;
	assign load_out_res  = ~skid_v_q & push & (~out_v_q | take);
	assign load_skid     = ~skid_v_q & push & out_v_q & ~take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_out_skid) begin
				skid_v_q <= 1'b0;
			end else if (load_out_res) begin
				out_v_q <= 1'b1;
			end else if (load_skid) begin
				skid_v_q <= 1'b1;
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_skid) begin
			out_q <= skid_q;
		end else if (load_out_res) begin
			out_q <= res;
		end
		if (load_skid) begin
			skid_q <= res;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule

// ===== rtl/positional_stack_engine_core.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | func, data_in, slot
// out     | output    | out_valid / out_stall | data_out, count, status
//
// one transaction per cycle unless in_stall is up: each operation
// finishes in the cycle it is accepted, its result is registered in the
// output queue; the cells at or below the position shift or load on
// that same edge, so insert and remove cost the same as push and pop
// arst_n clears the fill count and the output queue; entry words are not reset
// a two-deep output queue keeps in open while one result waits under out_stall
module positional_stack_engine_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         func,
	input  logic signed [pse_pkg::DATA_W-1:0]  data_in,
	input  logic [pse_pkg::SLOT_W-1:0]         slot,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pse_pkg::DATA_W-1:0]  data_out,
	output logic [pse_pkg::CNT_OUT_W-1:0]      count,
	output logic [1:0]                         status
);

	localparam int D = pse_pkg::DEPTH;

	// fill count, the only control state of the stack itself
	logic [pse_pkg::CNT_W-1:0] fill_q;
	logic [pse_pkg::CNT_W-1:0] fill_d;
	logic [pse_pkg::CMP_W-1:0] fill_x;
	logic [pse_pkg::CMP_W-1:0] pos_x;
	logic [pse_pkg::CMP_W-1:0] fill_d_x;
	logic                      is_full;
	logic                      in_acc;

	pse_pkg::shift_t     sh;
	pse_pkg::stat_t      st;
	logic                rd_en;
	logic [pse_pkg::CMP_W-1:0] op_pos;
	pse_pkg::cell_ctl_t  ctl;
	pse_pkg::result_t    res;
	pse_pkg::result_t    out_res;
	logic                q_full;

	logic signed [pse_pkg::DATA_W-1:0] words   [D];
	logic signed [pse_pkg::DATA_W-1:0] rd_taps [D];
	logic signed [pse_pkg::DATA_W-1:0] up_w    [D];
	logic signed [pse_pkg::DATA_W-1:0] dn_w    [D];
	logic signed [pse_pkg::DATA_W-1:0] rd_val;

	assign in_stall = q_full;
	assign in_acc   = in_valid & ~in_stall;

	assign fill_x  = pse_pkg::CMP_W'(fill_q);
	assign pos_x   = pse_pkg::CMP_W'(slot);
	assign is_full = (fill_x >= pse_pkg::CMP_W'(D));

	// operation decode against the current fill
	always_comb begin
		sh     = pse_pkg::SH_HOLD;
		st     = pse_pkg::ST_OK;
		rd_en  = 1'b0;
		op_pos = pos_x;
		fill_d = fill_q;
		unique case (pse_pkg::func_t'(func))
			pse_pkg::FN_PUSH: begin
				op_pos = '0;
				if (is_full) begin
					st = pse_pkg::ST_FULL;
				end else begin
					sh     = pse_pkg::SH_INSERT;
					fill_d = fill_q + pse_pkg::CNT_W'(1);
				end
			end
			pse_pkg::FN_POP: begin
				op_pos = '0;
				if (fill_q == '0) begin
					st = pse_pkg::ST_EMPTY;
				end else begin
					sh     = pse_pkg::SH_REMOVE;
					rd_en  = 1'b1;
					fill_d = fill_q - pse_pkg::CNT_W'(1);
				end
			end
			pse_pkg::FN_INSERT: begin
				// position is checked before fullness
				if (pos_x > fill_x) begin
					st = pse_pkg::ST_BADPOS;
				end else if (is_full) begin
					st = pse_pkg::ST_FULL;
				end else begin
					sh     = pse_pkg::SH_INSERT;
					fill_d = fill_q + pse_pkg::CNT_W'(1);
				end
			end
			pse_pkg::FN_REMOVE: begin
				if (pos_x >= fill_x) begin
					st = pse_pkg::ST_BADPOS;
				end else begin
					sh     = pse_pkg::SH_REMOVE;
					rd_en  = 1'b1;
					fill_d = fill_q - pse_pkg::CNT_W'(1);
				end
			end
			pse_pkg::FN_READ: begin
				if (pos_x >= fill_x) begin
					st = pse_pkg::ST_BADPOS;
				end else begin
					rd_en = 1'b1;
				end
			end
			default: begin
				// unused codes leave everything alone and report ok
				st = pse_pkg::ST_OK;
			end
		endcase
	end

	// cells only move on an accepted transaction
	always_comb begin
		ctl.shift = in_acc ? sh : pse_pkg::SH_HOLD;
		ctl.pos   = op_pos;
		ctl.wdata = data_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc) begin
			fill_q <= fill_d;
		end
	end

	// neighbor wiring: top cell gets data_in from above, bottom cell refills itself
	for (genvar i = 0; i < D; i++) begin : g_cell
		if (i == 0) begin : g_top
			assign up_w[i] = data_in;
		end else begin : g_mid_up
			assign up_w[i] = words[i-1];
		end
		if (i == D - 1) begin : g_bot
			assign dn_w[i] = words[i];
		end else begin : g_mid_dn
			assign dn_w[i] = words[i+1];
		end

		pse_cell u_cell (
			.clk     (clk),
			.idx     (pse_pkg::IDX_W'(i)),
			.ctl     (ctl),
			.up_word (up_w[i]),
			.dn_word (dn_w[i]),
			.word    (words[i]),
			.rd_word (rd_taps[i])
		);
	end

	// at most one cell matches the position, so an or over the taps selects it
	always_comb begin
		rd_val = '0;
		for (int k = 0; k < D; k++) begin
			rd_val = rd_val | rd_taps[k];
		end
	end

	assign fill_d_x = pse_pkg::CMP_W'(fill_d);

	always_comb begin
		res.data   = rd_en ? rd_val : '0;
		res.count  = fill_d_x[pse_pkg::CNT_OUT_W-1:0];
		res.status = st;
	end

	pse_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.res       (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign data_out = out_res.data;
	assign count    = out_res.count;
	assign status   = out_res.status;

endmodule

// ===== rtl/pse_checker.sv =====
module pse_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [2:0]                         func,
	input  logic signed [pse_pkg::DATA_W-1:0]  data_in,
	input  logic [pse_pkg::SLOT_W-1:0]         slot,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [pse_pkg::DATA_W-1:0]  data_out,
	input  logic [pse_pkg::CNT_OUT_W-1:0]      count,
	input  logic [1:0]                         status
);

	localparam logic [pse_pkg::CNT_OUT_W-1:0] FULL_CNT =
		pse_pkg::CNT_OUT_W'(pse_pkg::DEPTH);

	// a held result does not change under stall
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out)
			&& $stable(count) && $stable(status))
		else $error("held result changed under stall");

	// any non-ok status carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pse_pkg::ST_OK |-> data_out == '0)
		else $error("error result with nonzero data");

	// empty on pop only when nothing is held
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pse_pkg::ST_EMPTY |-> count == '0)
		else $error("empty status with nonzero count");

	// full refusal only at capacity
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pse_pkg::ST_FULL |-> count == FULL_CNT)
		else $error("full status below capacity");

	// an input transaction with an empty output side shows a result next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> out_valid)
		else $error("accepted transaction produced no result");

endmodule

bind positional_stack_engine_core pse_checker u_pse_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;

	// unused operation codes, the block must answer them with ok and no change
	localparam logic [2:0] FN_NONE_LO  = 3'd5;
	localparam logic [2:0] FN_NONE_MID = 3'd6;
	localparam logic [2:0] FN_NONE_HI  = 3'd7;

	localparam int RAND_OPS    = 650;
	localparam int RESET_HOLD  = 12;
	localparam int DRAIN_WAIT  = 8;
	// no transaction on either side for this many cycles means a hang
	localparam int WATCH_LIMIT = 2000;

	typedef struct packed {
		logic [2:0]                        op;
		logic signed [pse_pkg::DATA_W-1:0] val;
		logic [pse_pkg::SLOT_W-1:0]        pos;
	} stack_req_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic [2:0]                          func = 3'd0;
	logic signed [pse_pkg::DATA_W-1:0]   data_in = '0;
	logic [pse_pkg::SLOT_W-1:0]          slot = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [pse_pkg::DATA_W-1:0]   data_out;
	logic [pse_pkg::CNT_OUT_W-1:0]       count;
	logic [1:0]                          status;

	// operations still to send, and results the stack owes us
	stack_req_t                          pending_ops[$];
	pse_pkg::result_t                    expected_results[$];

	// shadow copy of the stack, entry 0 is the top
	logic signed [pse_pkg::DATA_W-1:0]   stack_words[pse_pkg::DEPTH];
	int                                  stack_fill = 0;
	// fill as the generator sees it, used to aim positions and to fill the stack
	int                                  gen_fill = 0;

	int                                  errors = 0;
	int                                  ops_sent = 0;
	int                                  idle_cycles = 0;
	int                                  status_seen[4] = '{0, 0, 0, 0};
	bit                                  req_taken = 1'b0;
	int                                  in_gap = 0;
	int                                  stall_left = 0;
	bit                                  in_quiet = 1'b0;
	bit                                  out_quiet = 1'b0;

	positional_stack_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data_in   (data_in),
		.slot      (slot),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.count     (count),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// open a hole at pos and drop the value in, lower entries slide down
	function automatic void open_slot(input int pos,
			input logic signed [pse_pkg::DATA_W-1:0] val);
		for (int i = stack_fill; i > pos; i--)
			stack_words[i] = stack_words[i-1];
		stack_words[pos] = val;
		stack_fill++;
	endfunction

	// pull the entry at pos out, lower entries slide up
	function automatic logic signed [pse_pkg::DATA_W-1:0] close_slot(input int pos);
		logic signed [pse_pkg::DATA_W-1:0] v;
		v = stack_words[pos];
		for (int i = pos; i + 1 < stack_fill; i++)
			stack_words[i] = stack_words[i+1];
		stack_fill--;
		return v;
	endfunction

	// apply one operation to the shadow stack and return the answer it owes
	function automatic pse_pkg::result_t stack_apply(input logic [2:0] op,
			input logic signed [pse_pkg::DATA_W-1:0] val,
			input logic [pse_pkg::SLOT_W-1:0] pos);
		pse_pkg::result_t r;
		r.data   = '0;
		r.status = pse_pkg::ST_OK;
		case (op)
			pse_pkg::FN_PUSH: begin
				if (stack_fill >= pse_pkg::DEPTH)
					r.status = pse_pkg::ST_FULL;
				else
					open_slot(0, val);
			end
			pse_pkg::FN_POP: begin
				if (stack_fill == 0)
					r.status = pse_pkg::ST_EMPTY;
				else
					r.data = close_slot(0);
			end
			pse_pkg::FN_INSERT: begin
				// position is judged before fullness
				if (int'(pos) > stack_fill)
					r.status = pse_pkg::ST_BADPOS;
				else if (stack_fill >= pse_pkg::DEPTH)
					r.status = pse_pkg::ST_FULL;
				else
					open_slot(int'(pos), val);
			end
			pse_pkg::FN_REMOVE: begin
				if (int'(pos) >= stack_fill)
					r.status = pse_pkg::ST_BADPOS;
				else
					r.data = close_slot(int'(pos));
			end
			pse_pkg::FN_READ: begin
				if (int'(pos) >= stack_fill)
					r.status = pse_pkg::ST_BADPOS;
				else
					r.data = stack_words[pos];
			end
			default: ;
		endcase
		r.count = pse_pkg::CNT_OUT_W'(stack_fill);
		return r;
	endfunction

	// queue an operation and track how full the stack will be
	task automatic queue_op(input logic [2:0] op,
			input logic signed [pse_pkg::DATA_W-1:0] val,
			input logic [pse_pkg::SLOT_W-1:0] pos);
		pending_ops.push_back('{op, val, pos});
		case (op)
			pse_pkg::FN_PUSH:   if (gen_fill < pse_pkg::DEPTH) gen_fill++;
			pse_pkg::FN_POP:    if (gen_fill > 0) gen_fill--;
			pse_pkg::FN_INSERT: if (int'(pos) <= gen_fill && gen_fill < pse_pkg::DEPTH) gen_fill++;
			pse_pkg::FN_REMOVE: if (int'(pos) < gen_fill) gen_fill--;
			default: ;
		endcase
	endtask

	// mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// input driver, changes payload only on the falling edge
	always @(negedge clk) begin : drive_ops
		stack_req_t nxt;
		if (arst_n) begin
			if ($urandom_range(0, 49) == 0)
				in_quiet = !in_quiet;
			// a stalled transaction stays put until taken
			if (!in_valid || req_taken) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (pending_ops.size() > 0) begin
					nxt = pending_ops.pop_front();
					func     <= nxt.op;
					data_in  <= nxt.val;
					slot     <= nxt.pos;
					in_valid <= 1'b1;
					in_gap = pick_gap(in_quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 39) == 0)
				out_quiet = !out_quiet;
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap(out_quiet);
			end
		end
	end

	// monitor: check results, then predict what the accepted operation owes
	always @(posedge clk) begin : watch_ports
		pse_pkg::result_t want;
		bit               got;
		if (arst_n) begin
			req_taken = in_valid && !in_stall;
			got = out_valid && !out_stall;
			// compare first, the result on out never belongs to this edge's input
			if (got) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got data %0d count %0d status %0d",
						$time, data_out, count, status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					status_seen[want.status]++;
					if (data_out !== want.data) begin
						$display("%0t: data_out expected %0d got %0d", $time, want.data, data_out);
						errors++;
					end
					if (count !== want.count) begin
						$display("%0t: count expected %0d got %0d", $time, want.count, count);
						errors++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status, status);
						errors++;
					end
				end
			end
			if (req_taken) begin
				expected_results.push_back(stack_apply(func, data_in, slot));
				ops_sent++;
			end
			idle_cycles = (req_taken || got) ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCH_LIMIT);
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0]                        op;
		logic signed [pse_pkg::DATA_W-1:0] val;
		logic [pse_pkg::SLOT_W-1:0]        pos;
		int                                trend;
		int                                phase_left;
		int                                grow_pct;
		int                                r;

		// empty stack corner cases
		queue_op(pse_pkg::FN_POP, 32'sd5, 5'd0);
		queue_op(pse_pkg::FN_READ, 32'sd0, 5'd0);
		queue_op(pse_pkg::FN_REMOVE, 32'sd0, 5'd0);
		queue_op(pse_pkg::FN_INSERT, 32'sd9, 5'd1);
		queue_op(FN_NONE_LO, 32'sd1, 5'd3);
		queue_op(FN_NONE_MID, -32'sd1, 5'd31);
		queue_op(FN_NONE_HI, 32'sd2, 5'd16);
		// extremes of the value range
		queue_op(pse_pkg::FN_INSERT, 32'sh8000_0000, 5'd0);
		queue_op(pse_pkg::FN_PUSH, 32'sh7fff_ffff, 5'd31);
		queue_op(pse_pkg::FN_PUSH, -32'sd1, 5'd0);
		queue_op(pse_pkg::FN_PUSH, 32'sd0, 5'd0);
		// insert at the very bottom, remove from the middle, read out of range
		queue_op(pse_pkg::FN_INSERT, 32'sh5555_5555, 5'd4);
		queue_op(pse_pkg::FN_REMOVE, 32'sd0, 5'd2);
		queue_op(pse_pkg::FN_READ, 32'sd0, 5'd31);
		// fill to the brim, then hit the full cases
		while (gen_fill < pse_pkg::DEPTH)
			queue_op(pse_pkg::FN_PUSH, $urandom, 5'($urandom_range(0, 31)));
		queue_op(pse_pkg::FN_PUSH, 32'sd77, 5'd0);
		queue_op(pse_pkg::FN_INSERT, 32'sd78, 5'd3);
		queue_op(pse_pkg::FN_INSERT, 32'sd79, 5'd17);
		queue_op(pse_pkg::FN_READ, 32'sd0, 5'd15);
		queue_op(pse_pkg::FN_REMOVE, 32'sd0, 5'd15);
		queue_op(pse_pkg::FN_POP, 32'sd0, 5'd0);

		// random part: phases that fill, drain or churn the stack
		phase_left = 0;
		trend = 2;
		for (int n = 0; n < RAND_OPS; n++) begin
			if (phase_left == 0) begin
				trend = $urandom_range(0, 2);
				phase_left = $urandom_range(8, 40);
			end
			phase_left--;
			grow_pct = (trend == 0) ? 75 : (trend == 1) ? 25 : 50;
			r = $urandom_range(0, 99);
			if (r < 5)
				op = 3'($urandom_range(FN_NONE_LO, FN_NONE_HI));
			else if ($urandom_range(0, 99) < grow_pct)
				op = $urandom_range(0, 1) ? pse_pkg::FN_PUSH : pse_pkg::FN_INSERT;
			else begin
				case ($urandom_range(0, 2))
					0: op = pse_pkg::FN_POP;
					1: op = pse_pkg::FN_REMOVE;
					default: op = pse_pkg::FN_READ;
				endcase
			end
			// positions mostly legal for the current fill, some anywhere
			if (op == pse_pkg::FN_PUSH || op == pse_pkg::FN_POP || $urandom_range(0, 9) == 0)
				pos = 5'($urandom_range(0, 31));
			else if (op == pse_pkg::FN_INSERT)
				pos = 5'($urandom_range(0, gen_fill));
			else
				pos = (gen_fill > 0) ? 5'($urandom_range(0, gen_fill - 1)) : 5'd0;
			case ($urandom_range(0, 9))
				0: val = 32'sh8000_0000;
				1: val = 32'sh7fff_ffff;
				2: val = 32'($urandom_range(0, 15)) - 32'sd8;
				default: val = $urandom;
			endcase
			queue_op(op, val, pos);
		end

		repeat (RESET_HOLD) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
		// let anything stray still show up
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d stack operations with random gaps and back-pressure", ops_sent);
		$display("answers: %0d ok, %0d empty pops, %0d bad positions, %0d full refusals",
			status_seen[pse_pkg::ST_OK], status_seen[pse_pkg::ST_EMPTY],
			status_seen[pse_pkg::ST_BADPOS], status_seen[pse_pkg::ST_FULL]);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
